// ===== hw/rtl/utf8v_pkg.sv =====
// Package with the shared types and byte-class constants of the UTF-8 stream validator.
package utf8v_pkg;

  // Extra check applied to the first continuation byte after certain lead bytes.
  typedef enum logic [1:0] {
    RULE_NONE = 2'd0,  // no extra check
    RULE_ED   = 2'd1,  // after ED: byte must be in 80-9F
    RULE_E0   = 2'd2,  // after E0: byte must be A0 or above
    RULE_F0   = 2'd3   // after F0: byte must be 90 or above
  } rule_t;

  // Number of continuation bytes still expected.
  typedef logic [1:0] pend_t;

  localparam logic [7:0] LEAD_ED_BYTE   = 8'hED;
  localparam logic [7:0] C2_MASK        = 8'h1E;
  localparam logic [7:0] E0_MASK        = 8'h0F;
  localparam logic [7:0] F0_MASK        = 8'h07;
  localparam logic [7:0] CONT_MASK      = 8'hC0;
  localparam logic [7:0] CONT_PATTERN   = 8'h80;
  localparam logic [7:0] ED_CONT_MAX    = 8'h9F;
  localparam logic [7:0] E0_CONT_BIT    = 8'h20;
  localparam logic [7:0] F0_CONT_BITS   = 8'h30;

  // Result of one state update step.
  typedef struct packed {
    pend_t pend;
    rule_t rule;
    logic  err;
  } scan_state_t;

endpackage

// ===== hw/rtl/utf8_stream_validator.sv =====
// Top level of the UTF-8 stream validator: input register, state update and result register.

// The validator checks a UTF-8 string that arrives one byte per input transfer and
// gives exactly one result transfer, string_valid, when the string closes: on a
// transfer with in_end_only set (its data byte is ignored), or after checking the
// byte of a transfer with in_last_byte set. An end-only transfer with no bytes
// before it reports an empty string as valid. The first error in a string is kept
// until the string closes, and an unfinished multi-byte sequence at the close is an
// error. Throughput is one byte per clock cycle while the input is not stalled; a
// closing transfer passes the input register, then the result register. The block only
// stalls its input when a closing transfer reaches the state-update stage while the
// result register still holds a verdict that the consumer has not taken; bytes that
// do not close a string never wait for the result side.
module utf8_stream_validator (
  input  logic       clk,
  input  logic       rst_n,
  // Input channel.
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  logic       in_end_only,
  // Result channel.
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_string_valid
);
  import utf8v_pkg::*;

  // Input register stage.
  logic       s1_vld_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_end_r;

  // Scanner state for the string in progress.
  pend_t pend_r;
  rule_t rule_r;
  logic  err_r;

  // Result register.
  logic out_vld_r;
  logic out_sv_r;

  logic        s1_closes;
  logic        out_slot_free;
  logic        s1_adv;
  scan_state_t byte_nxt;
  scan_state_t scan_nxt;
  logic        verdict_nxt;

  // A closing item needs room in the result register; other items always move on.
  assign s1_closes     = s1_end_r | s1_last_r;
  assign out_slot_free = ~out_vld_r | out_ready;
  assign s1_adv        = s1_vld_r & (~s1_closes | out_slot_free);
  assign in_ready      = ~s1_vld_r | s1_adv;

  // State update for one data byte. When no continuation byte is pending the byte
  // is treated as a lead byte; otherwise it is the next continuation byte, and a
  // byte that is not of the form 10xxxxxx is flagged but still counted.
  always_comb begin
    byte_nxt.pend = pend_r;
    byte_nxt.rule = rule_r;
    byte_nxt.err  = err_r;
    if (pend_r == pend_t'(0)) begin
      byte_nxt.rule = RULE_NONE;
      if (s1_byte_r[7] == 1'b0) begin
        // Plain ASCII.
        byte_nxt.pend = pend_t'(0);
      end else if (s1_byte_r[6] == 1'b0) begin
        // Stray continuation byte in lead position.
        byte_nxt.err  = 1'b1;
        byte_nxt.pend = pend_t'(0);
      end else if (s1_byte_r[5] == 1'b0) begin
        // Two-byte lead; C0 and C1 would encode overlong forms.
        if ((s1_byte_r & C2_MASK) == 8'h00) begin
          byte_nxt.err = 1'b1;
        end
        byte_nxt.pend = pend_t'(1);
      end else if (s1_byte_r[4] == 1'b0) begin
        // Three-byte lead; ED excludes surrogates and E0 excludes overlong forms.
        if (s1_byte_r == LEAD_ED_BYTE) begin
          byte_nxt.rule = RULE_ED;
        end else if ((s1_byte_r & E0_MASK) == 8'h00) begin
          byte_nxt.rule = RULE_E0;
        end
        byte_nxt.pend = pend_t'(2);
      end else if (s1_byte_r[3] == 1'b0) begin
        // Four-byte lead; F0 excludes overlong forms.
        if ((s1_byte_r & F0_MASK) == 8'h00) begin
          byte_nxt.rule = RULE_F0;
        end
        byte_nxt.pend = pend_t'(3);
      end else begin
        // F8-FF never appear in UTF-8.
        byte_nxt.err  = 1'b1;
        byte_nxt.pend = pend_t'(0);
      end
    end else begin
      if ((s1_byte_r & CONT_MASK) != CONT_PATTERN) begin
        byte_nxt.err = 1'b1;
      end
      unique case (rule_r)
        RULE_ED: begin
          if ((s1_byte_r < CONT_PATTERN) || (s1_byte_r > ED_CONT_MAX)) begin
            byte_nxt.err = 1'b1;
          end
        end
        RULE_E0: begin
          if ((s1_byte_r & E0_CONT_BIT) == 8'h00) begin
            byte_nxt.err = 1'b1;
          end
        end
        RULE_F0: begin
          if ((s1_byte_r & F0_CONT_BITS) == 8'h00) begin
            byte_nxt.err = 1'b1;
          end
        end
        default: begin
        end
      endcase
      byte_nxt.rule = RULE_NONE;
      byte_nxt.pend = pend_r - pend_t'(1);
    end
  end

  // An end-only item carries no byte. A closing item produces the verdict and
  // returns the scanner to its idle state.
  always_comb begin
    if (s1_end_r) begin
      scan_nxt.pend = pend_r;
      scan_nxt.rule = rule_r;
      scan_nxt.err  = err_r;
    end else begin
      scan_nxt = byte_nxt;
    end
    verdict_nxt = ~scan_nxt.err & (scan_nxt.pend == pend_t'(0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      pend_r    <= pend_t'(0);
      rule_r    <= RULE_NONE;
      err_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_vld_r <= in_valid;
      end
      if (s1_adv) begin
        if (s1_closes) begin
          pend_r <= pend_t'(0);
          rule_r <= RULE_NONE;
          err_r  <= 1'b0;
        end else begin
          pend_r <= scan_nxt.pend;
          rule_r <= scan_nxt.rule;
          err_r  <= scan_nxt.err;
        end
      end
      if (s1_adv && s1_closes) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
      s1_end_r  <= in_end_only;
    end
    if (s1_adv && s1_closes) begin
      out_sv_r <= verdict_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_string_valid = out_sv_r;

  // A second-byte rule only exists while continuation bytes are pending.
  a_rule_needs_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (rule_r != RULE_NONE) |-> (pend_r != pend_t'(0)))
    else $error("second-byte rule set with no pending continuation byte");

  // A rule is set only by its lead byte, so the pending count matches the lead.
  a_rule_pend_match: assert property (@(posedge clk) disable iff (!rst_n)
    ((rule_r == RULE_F0) |-> (pend_r == pend_t'(3))) and
    (((rule_r == RULE_ED) || (rule_r == RULE_E0)) |-> (pend_r == pend_t'(2))))
    else $error("second-byte rule does not match pending count");

  // Closing a string clears all scanner state.
  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_closes) |=> ((pend_r == pend_t'(0)) && (rule_r == RULE_NONE) && !err_r))
    else $error("scanner state not cleared after string close");

  // The input stage only holds back when a verdict is blocked by a full result register.
  a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !s1_adv) |-> (s1_closes && out_vld_r && !out_ready))
    else $error("input stage stalled without a blocked verdict");

endmodule

// ===== dv/utf8_stream_validator_test.sv =====
// Self-checking testbench for the UTF-8 stream validator with a verdict scoreboard.
module utf8_stream_validator_test;
  import utf8v_pkg::*;

  // A run that accepts nothing on either channel for this many cycles is hung.
  // The slowest correct stretch is the long receiver hold-off plus a few random gaps.
  localparam int WATCHDOG_LIMIT = 5000;
  // Length of the forced receiver hold-off that backs up the result register.
  localparam int HOLD_CYCLES    = 300;
  // Cycles to keep watching after the last verdict.
  localparam int DRAIN_CYCLES   = 10;

  // Tracks the scan state of the current string the same way the block does and
  // keeps the verdicts that closing transfers have earned but not yet delivered.
  class verdict_scoreboard;
    pend_t pend;
    rule_t rule;
    logic  err;
    logic  verdict_q[$];
    int    mismatches;

    function new();
      pend       = '0;
      rule       = RULE_NONE;
      err        = 1'b0;
      mismatches = 0;
    endfunction

    // Called for every accepted input transfer.
    function void note_input(logic [7:0] b, logic last, logic end_only);
      if (!end_only) begin
        if (pend == 0) begin
          // Lead byte: classify it and arm the second-byte rule where needed.
          rule = RULE_NONE;
          if (b < CONT_PATTERN) begin
            pend = 2'd0;
          end else if (b < CONT_MASK) begin
            err  = 1'b1;
            pend = 2'd0;
          end else if (b < 8'hE0) begin
            // C0 and C1 would only encode overlong forms.
            if ((b & C2_MASK) == 8'h00) err = 1'b1;
            pend = 2'd1;
          end else if (b < 8'hF0) begin
            if (b == LEAD_ED_BYTE) rule = RULE_ED;
            else if ((b & E0_MASK) == 8'h00) rule = RULE_E0;
            pend = 2'd2;
          end else if (b < 8'hF8) begin
            if ((b & F0_MASK) == 8'h00) rule = RULE_F0;
            pend = 2'd3;
          end else begin
            err  = 1'b1;
            pend = 2'd0;
          end
        end else begin
          // Continuation byte: a wrong one still uses up a pending slot.
          if ((b & CONT_MASK) != CONT_PATTERN) err = 1'b1;
          case (rule)
            RULE_ED: if (b < CONT_PATTERN || b > ED_CONT_MAX) err = 1'b1;
            RULE_E0: if ((b & E0_CONT_BIT) == 8'h00) err = 1'b1;
            RULE_F0: if ((b & F0_CONT_BITS) == 8'h00) err = 1'b1;
            default: ;
          endcase
          rule = RULE_NONE;
          pend = pend - 2'd1;
        end
      end
      if (end_only || last) begin
        verdict_q.push_back(!err && pend == 2'd0);
        pend = '0;
        rule = RULE_NONE;
        err  = 1'b0;
      end
    endfunction

    // Called for every accepted result transfer.
    function void check_result(logic actual);
      logic want;
      if (verdict_q.size() == 0) begin
        $display("%0t: verdict %0b arrived with no string closed", $time, actual);
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        if (want !== actual) begin
          $display("%0t: string_valid mismatch, expected %0b, actual %0b",
                   $time, want, actual);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic       clk              = 1'b0;
  logic       rst_n            = 1'b0;
  logic       in_valid         = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte     = 8'h00;
  logic       in_last_byte     = 1'b0;
  logic       in_end_only      = 1'b0;
  logic       out_valid;
  logic       out_ready        = 1'b0;
  logic       out_string_valid;

  // Idle and stall rates in percent, set per phase by the main process.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // Raised by the main process to start the long receiver hold-off.
  bit hold_request   = 1'b0;
  int items_sent     = 0;
  int quiet_cycles   = 0;

  verdict_scoreboard sb = new();

  utf8_stream_validator u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .in_end_only      (in_end_only),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_string_valid (out_string_valid)
  );

  always #5 clk = ~clk;

  // Both channels are sampled at the rising edge, where the testbench inputs
  // have been stable since the falling edge. The same block runs the watchdog:
  // any transfer on either side counts as progress.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_data_byte, in_last_byte, in_end_only);
      if (out_valid && out_ready) sb.check_result(out_string_valid);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[utf8_stream_validator] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Receiver. Each falling edge it decides whether to take a result in the
  // next cycle. When a hold-off is requested it keeps out_ready low for a
  // fixed count of cycles, counted here, so the result register stays full
  // and the next closing transfer has to wait at the input.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offers one input transfer. Entered and left at a falling edge; valid is
  // lowered only for idle cycles, so back-to-back transfers keep it high.
  task automatic send_item(input logic [7:0] b, input logic last, input logic end_only);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    in_end_only  <= end_only;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Builds one string of up to max_chars characters, mostly well-formed with
  // random code points across every lead class, and sometimes broken on purpose:
  // a byte overwritten, a sequence cut short, a stray byte slipped in, or pure
  // noise. The string is then closed either on its last byte or by an end-only
  // transfer whose data byte and last flag are random.
  task automatic send_string(input int max_chars);
    logic [7:0] str_q[$];
    logic [7:0] lead;
    int         n_chars;
    int         pos;
    bit         close_on_byte;
    n_chars = $urandom_range(max_chars, 0);
    for (int c = 0; c < n_chars; c++) begin
      case ($urandom_range(3, 0))
        0: str_q.push_back(8'($urandom_range(8'h7F, 8'h00)));
        1: begin
          str_q.push_back(8'($urandom_range(8'hDF, 8'hC2)));
          str_q.push_back(8'($urandom_range(8'hBF, 8'h80)));
        end
        2: begin
          lead = 8'($urandom_range(8'hEF, 8'hE0));
          str_q.push_back(lead);
          if (lead == 8'hE0) str_q.push_back(8'($urandom_range(8'hBF, 8'hA0)));
          else if (lead == LEAD_ED_BYTE) str_q.push_back(8'($urandom_range(8'h9F, 8'h80)));
          else str_q.push_back(8'($urandom_range(8'hBF, 8'h80)));
          str_q.push_back(8'($urandom_range(8'hBF, 8'h80)));
        end
        default: begin
          // F4 90 and up and the leads F5-F7 are accepted by this block.
          lead = 8'($urandom_range(8'hF7, 8'hF0));
          str_q.push_back(lead);
          if (lead == 8'hF0) str_q.push_back(8'($urandom_range(8'hBF, 8'h90)));
          else str_q.push_back(8'($urandom_range(8'hBF, 8'h80)));
          str_q.push_back(8'($urandom_range(8'hBF, 8'h80)));
          str_q.push_back(8'($urandom_range(8'hBF, 8'h80)));
        end
      endcase
    end
    if ($urandom_range(99) < 25) begin
      case ($urandom_range(3, 0))
        0: if (str_q.size() > 0) begin
          pos        = $urandom_range(str_q.size() - 1, 0);
          str_q[pos] = 8'($urandom_range(255, 0));
        end
        1: if (str_q.size() > 0) void'(str_q.pop_back());
        2: begin
          pos = $urandom_range(str_q.size(), 0);
          str_q.insert(pos, 8'($urandom_range(255, 0)));
        end
        default: begin
          str_q.delete();
          repeat ($urandom_range(6, 1)) str_q.push_back(8'($urandom_range(255, 0)));
        end
      endcase
    end
    close_on_byte = (str_q.size() > 0) && ($urandom_range(3, 0) != 0);
    foreach (str_q[i]) send_item(str_q[i], close_on_byte && (i == str_q.size() - 1), 1'b0);
    if (!close_on_byte) send_item(8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)), 1'b1);
  endtask

  // One stretch of random strings under the given idle and stall rates.
  task automatic run_phase(input int idle_pct, input int stall_pct, input int n_items,
                           input int max_chars);
    int stop_at;
    stop_at        = items_sent + n_items;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (items_sent < stop_at) send_string(max_chars);
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed strings.
    // An end-only transfer with nothing before it is an empty, valid string.
    send_item(8'hA5, 1'b0, 1'b1);
    // ASCII extremes.
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h7F, 1'b1, 1'b0);
    // Smallest lead that is not overlong, highest continuation byte.
    send_item(8'hC2, 1'b0, 1'b0);
    send_item(8'hBF, 1'b1, 1'b0);
    // Overlong two-byte lead.
    send_item(8'hC1, 1'b0, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    // E0 with a second byte below A0 is overlong.
    send_item(8'hE0, 1'b0, 1'b0);
    send_item(8'h9F, 1'b0, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    // ED with a second byte above 9F would be a surrogate.
    send_item(8'hED, 1'b0, 1'b0);
    send_item(8'hA0, 1'b0, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    // F0 with a second byte below 90 is overlong.
    send_item(8'hF0, 1'b0, 1'b0);
    send_item(8'h8F, 1'b0, 1'b0);
    send_item(8'h80, 1'b0, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    // F4 90 is accepted, but the sequence is cut off by an end-only close
    // that also carries last_byte and a data byte that must be ignored.
    send_item(8'hF4, 1'b0, 1'b0);
    send_item(8'h90, 1'b0, 1'b0);
    send_item(8'h80, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    // Top byte as a lead.
    send_item(8'hFF, 1'b1, 1'b0);
    // A stray continuation byte sets the error; a good byte after it cannot clear it.
    send_item(8'h80, 1'b0, 1'b0);
    send_item(8'h41, 1'b1, 1'b0);
    // An ASCII byte where a continuation byte is due.
    send_item(8'hC3, 1'b0, 1'b0);
    send_item(8'h41, 1'b1, 1'b0);

    // Random strings under each idling mix.
    run_phase(0, 0, 80, 5);
    run_phase(79, 0, 80, 5);
    run_phase(0, 79, 80, 5);
    run_phase(36, 36, 80, 5);

    // Hold the receiver off while short strings keep coming at full rate, so
    // the result register fills and a closing transfer stalls the input.
    hold_request = 1'b1;
    run_phase(0, 0, 40, 2);

    in_valid       <= 1'b0;
    recv_stall_pct = 0;
    while (sb.verdict_q.size() != 0) @(posedge clk);
    // A few more cycles catch any verdict that should never have come.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("[utf8_stream_validator] OK");
    end else begin
      $display("[utf8_stream_validator] ERROR");
    end
    $finish;
  end

endmodule
